@@ rtl/core/chf_pkg.sv @@
// shared types and constants for the chunked body framer
package chf_pkg;

  localparam int CHF_COUNT_WIDTH = 64;

  // result queue depth and its count width
  localparam int CHF_Q_DEPTH = 3;
  localparam int CHF_Q_CW    = $clog2(CHF_Q_DEPTH + 1);

  localparam logic [7:0] CHF_CR  = 8'h0d;
  localparam logic [7:0] CHF_LF  = 8'h0a;
  localparam logic [7:0] CHF_SP  = 8'h20;
  localparam logic [7:0] CHF_TAB = 8'h09;

  typedef enum logic [1:0] {
    CLS_SIZE  = 2'd0,
    CLS_DATA  = 2'd1,
    CLS_POST  = 2'd2,
    CLS_TRAIL = 2'd3
  } cls_t;

  typedef struct packed {
    logic [7:0] value;
    cls_t       cls;
    logic       chunk_end;
    logic       body_end;
    logic       last;
  } res_t;

  // up to two results per byte, handed from parser to queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

@@ rtl/core/chf_parser.sv @@
// framing state machine: one input byte in, up to two tagged results out
module chf_parser import chf_pkg::*; #(
  parameter int COUNT_WIDTH = CHF_COUNT_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_vld,
  input  logic [7:0]          item_byte,
  input  logic [CHF_Q_CW-1:0] free,
  output logic                take,
  output push_t               push
);

  // counts never exceed the signed maximum, so the top bit is dropped
  localparam int AW = COUNT_WIDTH - 1;

  typedef enum logic [1:0] {
    PH_SIZE  = 2'd0,
    PH_DATA  = 2'd1,
    PH_POST  = 2'd2,
    PH_TRAIL = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    DG_LEAD = 2'd0,
    DG_IN   = 2'd1,
    DG_DONE = 2'd2
  } digits_t;

  phase_t        phase_r, phase_nxt;
  digits_t       digits_r, digits_nxt;
  logic [AW-1:0] accum_r, accum_nxt;
  logic [AW-1:0] left_r, left_nxt;
  logic          pend_r, pend_nxt;
  logic          lhc_r, lhc_nxt;
  logic          post_r, post_nxt;

  logic          is_cr, is_lf, is_blank, hex_ok;
  logic [3:0]    hex_d;
  logic          sat, data_end, eob;
  logic [AW-1:0] accum_step;
  digits_t       sz_digits;
  logic [AW-1:0] sz_accum;
  cls_t          cls_cur;
  logic [1:0]    n;
  res_t          r0, r1;

  function automatic logic [4:0] hex_dec(input logic [7:0] b);
    logic [4:0] res;
    res = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      res = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      res = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      res = {1'b1, 4'(b - 8'h37)};
    end
    return res;
  endfunction

  assign is_cr    = (item_byte == CHF_CR);
  assign is_lf    = (item_byte == CHF_LF);
  assign is_blank = (item_byte == CHF_SP) || (item_byte == CHF_TAB);
  assign {hex_ok, hex_d} = hex_dec(item_byte);

  // another digit overflows once any of the top four accumulator bits is set
  assign sat        = |accum_r[AW-1:AW-4];
  assign accum_step = sat ? '1 : {accum_r[AW-5:0], hex_d};

  assign data_end = (left_r[AW-1:1] == '0);
  assign eob      = (phase_r == PH_TRAIL) && !lhc_r;

  always_comb begin
    case (phase_r)
      PH_SIZE:  cls_cur = CLS_SIZE;
      PH_DATA:  cls_cur = CLS_DATA;
      PH_POST:  cls_cur = CLS_POST;
      default:  cls_cur = CLS_TRAIL;
    endcase
  end

  // size digit tracking for a content byte on a size line
  always_comb begin
    sz_digits = digits_r;
    sz_accum  = accum_r;
    if (digits_r == DG_DONE || (digits_r == DG_LEAD && is_blank)) begin
      sz_digits = digits_r;
    end else if (!hex_ok) begin
      sz_digits = DG_DONE;
    end else begin
      sz_digits = DG_IN;
      sz_accum  = accum_step;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    digits_nxt = digits_r;
    accum_nxt  = accum_r;
    left_nxt   = left_r;
    pend_nxt   = pend_r;
    lhc_nxt    = lhc_r;
    post_nxt   = post_r;
    n          = 2'd0;
    r0         = '0;
    r1         = '0;
    r0.cls     = cls_cur;
    r1.cls     = cls_cur;
    case (phase_r)
      PH_DATA: begin
        n            = 2'd1;
        r0.value     = item_byte;
        r0.chunk_end = data_end;
        r0.last      = 1'b1;
        left_nxt     = data_end ? '0 : left_r - AW'(1);
        if (data_end) begin
          phase_nxt = PH_POST;
          post_nxt  = 1'b0;
        end
      end
      PH_POST: begin
        n        = 2'd1;
        r0.value = item_byte;
        r0.last  = 1'b1;
        if (!post_r) begin
          post_nxt = 1'b1;
        end else begin
          post_nxt   = 1'b0;
          phase_nxt  = PH_SIZE;
          accum_nxt  = '0;
          digits_nxt = DG_LEAD;
          lhc_nxt    = 1'b0;
        end
      end
      default: begin
        if (is_lf) begin
          // line end, with or without a held cr
          n           = 2'd2;
          r0.value    = CHF_CR;
          r1.value    = CHF_LF;
          r1.body_end = eob;
          r1.last     = 1'b1;
          pend_nxt    = 1'b0;
          lhc_nxt     = 1'b0;
          if (phase_r == PH_SIZE) begin
            accum_nxt  = '0;
            digits_nxt = DG_LEAD;
            if (accum_r == '0) begin
              phase_nxt = PH_TRAIL;
            end else begin
              left_nxt  = accum_r;
              phase_nxt = PH_DATA;
            end
          end else if (eob) begin
            phase_nxt = PH_SIZE;
          end
        end else if (pend_r) begin
          // held cr was plain content; it ends any size digits
          r0.value = CHF_CR;
          lhc_nxt  = 1'b1;
          if (phase_r == PH_SIZE) begin
            digits_nxt = DG_DONE;
          end
          if (is_cr) begin
            n       = 2'd1;
            r0.last = 1'b1;
          end else begin
            n        = 2'd2;
            r1.value = item_byte;
            r1.last  = 1'b1;
            pend_nxt = 1'b0;
          end
        end else if (is_cr) begin
          pend_nxt = 1'b1;
        end else begin
          n        = 2'd1;
          r0.value = item_byte;
          r0.last  = 1'b1;
          lhc_nxt  = 1'b1;
          if (phase_r == PH_SIZE) begin
            digits_nxt = sz_digits;
            accum_nxt  = sz_accum;
          end
        end
      end
    endcase
  end

  assign take     = item_vld && (free >= CHF_Q_CW'(n));
  assign push.cnt = take ? n : 2'd0;
  assign push.r0  = r0;
  assign push.r1  = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIZE;
      digits_r <= DG_LEAD;
      accum_r  <= '0;
      left_r   <= '0;
      pend_r   <= 1'b0;
      lhc_r    <= 1'b0;
      post_r   <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      digits_r <= digits_nxt;
      accum_r  <= accum_nxt;
      left_r   <= left_nxt;
      pend_r   <= pend_nxt;
      lhc_r    <= lhc_nxt;
      post_r   <= post_nxt;
    end
  end

endmodule

@@ rtl/core/chf_out_queue.sv @@
// small shifting result queue in front of the output channel
module chf_out_queue import chf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  push_t               push,
  input  logic                out_ready,
  output logic                out_valid,
  output res_t                head,
  output logic [CHF_Q_CW-1:0] free
);

  res_t                q_r   [CHF_Q_DEPTH];
  res_t                q_nxt [CHF_Q_DEPTH];
  logic [CHF_Q_CW-1:0] count_r, count_nxt;
  logic [CHF_Q_CW-1:0] base;
  logic                pop;

  assign out_valid = (count_r != '0);
  assign head      = q_r[0];
  assign free      = CHF_Q_CW'(CHF_Q_DEPTH) - count_r;
  assign pop       = out_valid && out_ready;
  assign base      = count_r - CHF_Q_CW'(pop);
  assign count_nxt = base + CHF_Q_CW'(push.cnt);

  always_comb begin
    for (int i = 0; i < CHF_Q_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < CHF_Q_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    for (int i = 0; i < CHF_Q_DEPTH; i++) begin
      if (push.cnt != 2'd0 && CHF_Q_CW'(i) == base) begin
        q_nxt[i] = push.r0;
      end
      if (push.cnt == 2'd2 && CHF_Q_CW'(i) == base + CHF_Q_CW'(1)) begin
        q_nxt[i] = push.r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CHF_Q_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

@@ rtl/core/http_chunked_body_framer.sv @@
// HTTP chunked body framer top level
//
// Input channel in_valid/in_ready/in_byte carries the raw chunked body one
// byte per transaction. Output channel out_valid/out_ready carries each byte
// forwarded downstream with its class (size line, chunk data, post-data pair,
// trailer line), chunk_end, body_end and last_of_run flags.
// A result passes through the input register and the result queue before it
// shows on out_valid. Throughput: one byte per cycle while out_ready stays
// high. A byte that gives two results (a line end, or a held carriage return
// followed by ordinary content) takes two entries of the three-entry result
// queue, which drains one result per cycle.
// A carriage return on a size or trailer line gives no result until the next
// byte arrives.
// Reset (synchronous, rst_n low) empties the input register and result queue
// and returns the framer to waiting for a size line with a zero size.
// When the receiver stalls, up to three results wait in the queue and one
// more byte in the input register; in_ready drops while that byte's results
// do not fit in the queue, and out_ready has no combinational path to in_ready.
module http_chunked_body_framer import chf_pkg::*; #(
  parameter int COUNT_WIDTH = CHF_COUNT_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_byte_class,
  output logic       out_chunk_end,
  output logic       out_body_end,
  output logic       out_last_of_run
);

  logic                in_vld_r;
  logic [7:0]          in_byte_r;
  logic                take;
  push_t               push;
  res_t                head;
  logic [CHF_Q_CW-1:0] free;

  assign in_ready = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (take) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  chf_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (in_vld_r),
    .item_byte (in_byte_r),
    .free      (free),
    .take      (take),
    .push      (push)
  );

  chf_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .free      (free)
  );

  assign out_byte        = head.value;
  assign out_byte_class  = head.cls;
  assign out_chunk_end   = head.chunk_end;
  assign out_body_end    = head.body_end;
  assign out_last_of_run = head.last;

endmodule

@@ rtl/core/chf_checker.sv @@
// port-level assertions for the chunked body framer, bound to the top level
module chf_checker import chf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_byte_class,
  input logic       out_chunk_end,
  input logic       out_body_end,
  input logic       out_last_of_run
);

  // a stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_byte_class) && $stable(out_last_of_run))
    else $error("output payload changed while stalled");

  a_body_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_body_end |-> out_byte == CHF_LF
      && out_byte_class == CLS_TRAIL && out_last_of_run)
    else $error("body end not on the trailer line feed");

  a_chunk_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chunk_end |-> out_byte_class == CLS_DATA && out_last_of_run)
    else $error("chunk end outside chunk data");

  // a result outside chunk data and the post-data pair that is not the last of its byte is followed by another
  a_crlf_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run && out_byte_class != CLS_DATA
      && out_byte_class != CLS_POST |=> out_valid)
    else $error("first result of a pair not followed by the second");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind http_chunked_body_framer chf_checker u_chf_checker (.*);
